// ===== rtl/core/rfo_pkg.sv =====
// rfo_pkg: shared sizes, operation codes, payload and control types
// for the ring fifo with overwrite modes; no dependencies
`default_nettype none

package rfo_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W     = $clog2(DEPTH + 1);
    localparam int MODE_W     = 3;

    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_OLD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PUSH_NEW = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POP      = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [DATA_WIDTH-1:0] item_data;
    } item_t;

    typedef struct packed {
        logic [FILL_W-1:0]     fill_level;
        logic                  accepted;
        logic                  head_valid;
        logic [DATA_WIDTH-1:0] head_data;
    } result_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_t;

    // ring index add with wrap at DEPTH
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W+1)'(DEPTH))
        begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rfo_ctrl.sv =====
// rfo_ctrl: sequencer for one fifo operation, capture then execute
// depends on rfo_pkg
`default_nettype none

module rfo_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    output rfo_pkg::ctl_t    ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;
    logic done_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        ctl.capture = 1'b0;
        ctl.execute = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.execute = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rfo_dp.sv =====
// rfo_dp: entry storage, start index, fill count and result register
// depends on rfo_pkg
`default_nettype none

module rfo_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  rfo_pkg::ctl_t        ctl,
    input  rfo_pkg::item_t       item,
    output rfo_pkg::result_t     result
);

    logic [rfo_pkg::DATA_WIDTH-1:0] mem [rfo_pkg::DEPTH];

    rfo_pkg::item_t                 item_reg;
    logic [rfo_pkg::DATA_WIDTH-1:0] rd_reg;
    logic [rfo_pkg::IDX_W-1:0]      start_reg;
    logic [rfo_pkg::IDX_W-1:0]      start_next;
    logic [rfo_pkg::FILL_W-1:0]     fill_reg;
    logic [rfo_pkg::FILL_W-1:0]     fill_next;
    rfo_pkg::result_t               result_reg;
    rfo_pkg::result_t               result_next;

    logic                           full;
    logic                           empty;
    logic [rfo_pkg::IDX_W-1:0]      tail_idx;
    logic [rfo_pkg::IDX_W-1:0]      newest_idx;
    logic [rfo_pkg::IDX_W-1:0]      start_inc;
    logic                           wr_en;
    logic [rfo_pkg::IDX_W-1:0]      wr_addr;

    assign full       = (fill_reg == rfo_pkg::FILL_W'(rfo_pkg::DEPTH));
    assign empty      = (fill_reg == '0);
    assign tail_idx   = rfo_pkg::idx_add(start_reg, fill_reg[rfo_pkg::IDX_W-1:0]);
    assign newest_idx = rfo_pkg::idx_add(start_reg, rfo_pkg::IDX_W'(rfo_pkg::DEPTH - 1));
    assign start_inc  = rfo_pkg::idx_add(start_reg, rfo_pkg::IDX_W'(1));

    always_comb
    begin
        start_next             = start_reg;
        fill_next              = fill_reg;
        wr_en                  = 1'b0;
        wr_addr                = tail_idx;
        result_next            = result_reg;
        if (ctl.execute)
        begin
            result_next.accepted   = 1'b0;
            result_next.head_valid = 1'b0;
            result_next.head_data  = '0;
            case (item_reg.mode)
                rfo_pkg::MODE_CLEAR:
                begin
                    start_next = '0;
                    fill_next  = '0;
                end
                rfo_pkg::MODE_PUSH:
                begin
                    if (!full)
                    begin
                        wr_en                = 1'b1;
                        fill_next            = fill_reg + 1'b1;
                        result_next.accepted = 1'b1;
                    end
                end
                rfo_pkg::MODE_PUSH_OLD:
                begin
                    wr_en                = 1'b1;
                    result_next.accepted = 1'b1;
                    if (!full)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        wr_addr    = start_reg;
                        start_next = start_inc;
                    end
                end
                rfo_pkg::MODE_PUSH_NEW:
                begin
                    wr_en                = 1'b1;
                    result_next.accepted = 1'b1;
                    if (!full)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        wr_addr = newest_idx;
                    end
                end
                rfo_pkg::MODE_PEEK:
                begin
                    if (!empty)
                    begin
                        result_next.head_valid = 1'b1;
                        result_next.head_data  = rd_reg;
                    end
                end
                rfo_pkg::MODE_POP:
                begin
                    if (!empty)
                    begin
                        result_next.head_valid = 1'b1;
                        result_next.head_data  = rd_reg;
                        start_next             = start_inc;
                        fill_next              = fill_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            result_next.fill_level = fill_next;
        end
    end

    // storage, no reset; head read is registered on capture
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item_reg.item_data;
        end
        if (ctl.capture)
        begin
            rd_reg   <= mem[start_reg];
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            start_reg <= start_next;
            fill_reg  <= fill_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ring_fifo_overwrite_modes_top.sv =====
// ring_fifo_overwrite_modes_top: ring fifo with clear, push, overwrite pushes,
// peek and pop; depends on rfo_pkg, rfo_ctrl, rfo_dp
// result: done and result are registered at the end of the execute state; done is one cycle wide
// a new operation is taken only after the last one has left the execute state
// reset: start index and fill count clear at once; storage is not cleared
// the receiver cannot stall: done marks each result for one cycle
`default_nettype none

module ring_fifo_overwrite_modes_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  rfo_pkg::item_t     item,
    output logic               busy,
    output logic               done,
    output rfo_pkg::result_t   result
);

    rfo_pkg::ctl_t ctl;

    rfo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    rfo_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .result (result)
    );

`ifndef SYNTHESIS
    // a transfer in always leads to exactly one execute cycle then a strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 (done && !busy))
        else $error("accepted operation did not complete in two cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.fill_level <= rfo_pkg::FILL_W'(rfo_pkg::DEPTH)))
        else $error("fill level beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.accepted && result.head_valid))
        else $error("push and head result flagged together");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.head_valid) |-> (result.head_data == '0))
        else $error("head data not zero without a valid head");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for ring_fifo_overwrite_modes_top: directed and random fifo operations,
// each result checked against a behavioural model of the ring held in this file
// depends on rfo_pkg and ring_fifo_overwrite_modes_top
`timescale 1ns / 1ps

module testbench;

    localparam logic [rfo_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [rfo_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    rfo_pkg::item_t   item = '0;
    logic             busy;
    logic             done;
    rfo_pkg::result_t result;

    ring_fifo_overwrite_modes_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // model of the ring
    logic [rfo_pkg::DATA_WIDTH-1:0] model_mem [rfo_pkg::DEPTH];
    logic [rfo_pkg::IDX_W-1:0]      model_head = '0;
    logic [rfo_pkg::FILL_W-1:0]     model_fill = '0;

    rfo_pkg::result_t pending_results [$];
    rfo_pkg::result_t expected_res;
    int      sender_idle_pct = 0;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      ops_sent = 0;
    int      refused_pushes = 0;
    int      full_overwrites = 0;
    int      empty_reads = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [rfo_pkg::IDX_W-1:0] ring_slot(
        input logic [rfo_pkg::IDX_W-1:0] base,
        input int                        offset);
        return rfo_pkg::IDX_W'((int'(base) + offset) % rfo_pkg::DEPTH);
    endfunction

    function automatic rfo_pkg::result_t apply_fifo_op(input rfo_pkg::item_t op);
        rfo_pkg::result_t r;
        logic             full;
        r = '0;
        full = (int'(model_fill) >= rfo_pkg::DEPTH);
        case (op.mode)
            rfo_pkg::MODE_CLEAR:
            begin
                model_head = '0;
                model_fill = '0;
            end
            rfo_pkg::MODE_PUSH:
            begin
                if (!full)
                begin
                    model_mem[ring_slot(model_head, int'(model_fill))] = op.item_data;
                    model_fill = model_fill + 1'b1;
                    r.accepted = 1'b1;
                end
                else
                begin
                    refused_pushes++;
                end
            end
            rfo_pkg::MODE_PUSH_OLD, rfo_pkg::MODE_PUSH_NEW:
            begin
                if (!full)
                begin
                    model_mem[ring_slot(model_head, int'(model_fill))] = op.item_data;
                    model_fill = model_fill + 1'b1;
                end
                else if (op.mode == rfo_pkg::MODE_PUSH_OLD)
                begin
                    model_mem[model_head] = op.item_data;
                    model_head = ring_slot(model_head, 1);
                    full_overwrites++;
                end
                else
                begin
                    model_mem[ring_slot(model_head, rfo_pkg::DEPTH - 1)] = op.item_data;
                    full_overwrites++;
                end
                r.accepted = 1'b1;
            end
            rfo_pkg::MODE_PEEK, rfo_pkg::MODE_POP:
            begin
                if (model_fill != '0)
                begin
                    r.head_valid = 1'b1;
                    r.head_data = model_mem[model_head];
                    if (op.mode == rfo_pkg::MODE_POP)
                    begin
                        model_head = ring_slot(model_head, 1);
                        model_fill = model_fill - 1'b1;
                    end
                end
                else
                begin
                    empty_reads++;
                end
            end
            default:
            begin
            end
        endcase
        r.fill_level = model_fill;
        return r;
    endfunction

    // one transfer: optional idle cycles, then start held until busy is low
    task automatic issue_op(input logic [rfo_pkg::MODE_W-1:0]     mode,
                            input logic [rfo_pkg::DATA_WIDTH-1:0] data);
        rfo_pkg::item_t op;
        op.mode = mode;
        op.item_data = data;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item <= op;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(apply_fifo_op(op));
        ops_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing outstanding");
                fail_count++;
            end
            else
            begin
                expected_res = pending_results.pop_front();
                if (result.fill_level !== expected_res.fill_level)
                begin
                    $error("fill_level expected %0d actual %0d",
                           expected_res.fill_level, result.fill_level);
                    fail_count++;
                end
                if (result.accepted !== expected_res.accepted)
                begin
                    $error("accepted expected %0d actual %0d",
                           expected_res.accepted, result.accepted);
                    fail_count++;
                end
                if (result.head_valid !== expected_res.head_valid)
                begin
                    $error("head_valid expected %0d actual %0d",
                           expected_res.head_valid, result.head_valid);
                    fail_count++;
                end
                if (result.head_data !== expected_res.head_data)
                begin
                    $error("head_data expected %08h actual %08h",
                           expected_res.head_data, result.head_data);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_fifo();
        issue_op(rfo_pkg::MODE_PEEK, '1);
        issue_op(rfo_pkg::MODE_POP, '1);
        issue_op(MODE_SPARE_B, '1);
    endtask

    task automatic test_fill_to_full();
        logic [rfo_pkg::DATA_WIDTH-1:0] data;
        logic [rfo_pkg::MODE_W-1:0]     mode;
        for (int i = 0; i < rfo_pkg::DEPTH; i++)
        begin
            case (i)
                0: data = '0;
                1: data = '1;
                2: data = {1'b1, {(rfo_pkg::DATA_WIDTH-1){1'b0}}};
                3: data = rfo_pkg::DATA_WIDTH'(1);
                default: data = rfo_pkg::DATA_WIDTH'($urandom);
            endcase
            // last two slots taken by the overwrite pushes while not yet full
            if (i == rfo_pkg::DEPTH - 2)
                mode = rfo_pkg::MODE_PUSH_OLD;
            else if (i == rfo_pkg::DEPTH - 1)
                mode = rfo_pkg::MODE_PUSH_NEW;
            else
                mode = rfo_pkg::MODE_PUSH;
            issue_op(mode, data);
        end
    endtask

    task automatic test_full_pushes();
        issue_op(rfo_pkg::MODE_PUSH, rfo_pkg::DATA_WIDTH'($urandom));
        issue_op(rfo_pkg::MODE_PUSH_OLD, rfo_pkg::DATA_WIDTH'($urandom));
        issue_op(rfo_pkg::MODE_PUSH_NEW, rfo_pkg::DATA_WIDTH'($urandom));
        issue_op(rfo_pkg::MODE_PEEK, '0);
        issue_op(rfo_pkg::MODE_POP, '0);
    endtask

    task automatic test_clear();
        issue_op(rfo_pkg::MODE_CLEAR, '1);
        issue_op(rfo_pkg::MODE_POP, '0);
    endtask

    task automatic test_random(input int n_ops);
        int                             burst_left;
        logic                           push_heavy;
        int                             roll;
        logic [rfo_pkg::MODE_W-1:0]     mode;
        logic [rfo_pkg::DATA_WIDTH-1:0] data;
        burst_left = 0;
        push_heavy = 1'b1;
        for (int i = 0; i < n_ops; i++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 4);
                push_heavy = 1'($urandom_range(1));
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < 1)
                mode = rfo_pkg::MODE_CLEAR;
            else if (roll < 3)
                mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
            else if (roll < (push_heavy ? 63 : 20))
                mode = rfo_pkg::MODE_W'($urandom_range(int'(rfo_pkg::MODE_PUSH_NEW),
                                                       int'(rfo_pkg::MODE_PUSH)));
            else if (roll < (push_heavy ? 80 : 40))
                mode = rfo_pkg::MODE_PEEK;
            else
                mode = rfo_pkg::MODE_POP;
            roll = $urandom_range(9);
            data = (roll == 0) ? '0 : (roll == 1) ? '1 : rfo_pkg::DATA_WIDTH'($urandom);
            issue_op(mode, data);
            if ($urandom_range(199) == 0)
                wait_all_results();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 36;
        test_empty_fifo();
        test_fill_to_full();
        test_full_pushes();
        test_clear();
        wait_all_results();

        test_random(575);
        wait_all_results();
        sender_idle_pct = 85;
        test_random(575);
        wait_all_results();
        sender_idle_pct = 0;
        test_random(575);
        wait_all_results();

        $display("%0d operations over sender idle rates of 36, 85 and 0 per cent", ops_sent);
        $display("%0d refused pushes, %0d overwrites of a full ring, %0d reads when empty",
                 refused_pushes, full_overwrites, empty_reads);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rfo_pkg.sv
rtl/core/rfo_ctrl.sv
rtl/core/rfo_dp.sv
rtl/core/ring_fifo_overwrite_modes_top.sv
sim/testbench.sv
